FILE: rtl/fkr_pkg.sv
`timescale 1ns / 1ps

package fkr_pkg;

   localparam int DEPTH       = 16;
   localparam int HANDLE_BITS = 16;
   localparam int PTR_BITS    = $clog2(DEPTH);
   localparam int CNT_BITS    = $clog2(DEPTH + 1);
   localparam int FUNC_BITS   = 2;
   localparam int STATUS_BITS = 2;

   // Stream widths: fields packed from bit 0 upwards, padded to whole bytes.
   localparam int REQ_TDATA_BITS = ((HANDLE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((HANDLE_BITS + CNT_BITS + 7) / 8) * 8;

   localparam logic [FUNC_BITS-1:0] FUNC_PUSH   = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_SHIFT  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd3;

   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEPTH);

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [HANDLE_BITS-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [HANDLE_BITS-1:0] out_handle;
      logic [CNT_BITS-1:0]    occupancy;
   } rsp_type;

   // Physical slot of the entry that lies offs places behind the head.
   function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] base,
                                                    input logic [CNT_BITS-1:0] offs);
      logic [CNT_BITS:0] sum;
      sum = (CNT_BITS + 1)'(base) + (CNT_BITS + 1)'(offs);
      if (sum >= (CNT_BITS + 1)'(DEPTH)) begin
         sum = sum - (CNT_BITS + 1)'(DEPTH);
      end
      return sum[PTR_BITS-1:0];
   endfunction

endpackage

FILE: rtl/fkr_ram.sv
`timescale 1ns / 1ps

module fkr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fkr_engine.sv
`timescale 1ns / 1ps

module fkr_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  fkr_pkg::req_type req,
   output logic             req_ready,
   input  logic             out_free,
   output logic             rsp_valid,
   output fkr_pkg::rsp_type rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [fkr_pkg::PTR_BITS-1:0]      head_ff, head_in;
   logic [fkr_pkg::CNT_BITS-1:0]      count_ff, count_in;
   logic [fkr_pkg::HANDLE_BITS-1:0]   key_ff, key_in;
   logic [fkr_pkg::CNT_BITS-1:0]      idx_ff, idx_in;
   logic [fkr_pkg::CNT_BITS-1:0]      rd_idx_ff, rd_idx_in;
   logic                              rd_valid_ff, rd_valid_in;
   logic                              found_ff, found_in;
   fkr_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                              wr_en, rd_en;
   logic [fkr_pkg::PTR_BITS-1:0]      wr_addr, rd_addr;
   logic [fkr_pkg::HANDLE_BITS-1:0]   wr_data, rd_data;
   logic                              match;

   fkr_ram #(
      .WIDTH(fkr_pkg::HANDLE_BITS),
      .DEPTH(fkr_pkg::DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE) && out_free;
   assign rsp       = rsp_ff;
   assign match     = (rd_data == key_ff);

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      rd_idx_in   = rd_idx_ff;
      rd_valid_in = 1'b0;
      found_in    = found_ff;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      wr_addr     = fkr_pkg::ptr_add(head_ff, count_ff);
      wr_data     = req.handle;
      rd_en       = 1'b0;
      rd_addr     = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rsp_in = '{status: fkr_pkg::STATUS_OK, out_handle: '0, occupancy: count_ff};
               state_in = ST_DONE;
               case (req.func)
                  fkr_pkg::FUNC_PUSH: begin
                     if (count_ff == fkr_pkg::DEPTH_CNT) begin
                        rsp_in.status = fkr_pkg::STATUS_FULL;
                     end else begin
                        wr_en            = 1'b1;
                        count_in         = count_ff + 1'b1;
                        rsp_in.occupancy = count_ff + 1'b1;
                     end
                  end
                  fkr_pkg::FUNC_SHIFT: begin
                     if (count_ff == '0) begin
                        rsp_in.status = fkr_pkg::STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_SHIFT;
                     end
                  end
                  fkr_pkg::FUNC_REMOVE: begin
                     if (req.handle == '0 || count_ff == '0) begin
                        rsp_in.status = fkr_pkg::STATUS_NOT_FOUND;
                     end else begin
                        key_in   = req.handle;
                        idx_in   = '0;
                        found_in = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            rsp_in = '{status: fkr_pkg::STATUS_OK, out_handle: rd_data,
                       occupancy: count_ff - 1'b1};
            head_in  = fkr_pkg::ptr_add(head_ff, fkr_pkg::CNT_BITS'(1));
            count_in = count_ff - 1'b1;
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // Reads run one entry ahead of the compare; once the key is
            // seen, every later entry is written one place nearer the head.
            if (idx_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = fkr_pkg::ptr_add(head_ff, idx_ff);
               rd_valid_in = 1'b1;
               rd_idx_in   = idx_ff;
               idx_in      = idx_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = fkr_pkg::ptr_add(head_ff, rd_idx_ff - 1'b1);
                  wr_data = rd_data;
               end else if (match) begin
                  found_in = 1'b1;
               end
               if (rd_idx_ff == count_ff - 1'b1) begin
                  rd_valid_in = 1'b0;
                  state_in    = ST_DONE;
                  if (found_ff || match) begin
                     count_in = count_ff - 1'b1;
                     rsp_in   = '{status: fkr_pkg::STATUS_OK, out_handle: '0,
                                  occupancy: count_ff - 1'b1};
                  end else begin
                     rsp_in   = '{status: fkr_pkg::STATUS_NOT_FOUND, out_handle: '0,
                                  occupancy: count_ff};
                  end
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
         found_ff    <= found_in;
      end
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
   end

endmodule

FILE: rtl/fifo_with_keyed_removal.sv
`timescale 1ns / 1ps

// A bounded queue of up to 16 connection handles held as a ring buffer in one
// synchronous RAM (one write and one registered read per cycle). Each request
// transaction names an operation in req_tuser: push appends the handle at the
// tail, shift takes and returns the head, and remove deletes the first entry
// from the head that equals the handle, keeping the order of the others. Every
// request yields exactly one response transaction giving a status, the handle
// taken on a successful shift (otherwise zero) and the occupancy afterwards.
// A push into a full queue is refused with status full, a shift of an empty
// queue reports empty, and removing the null handle or an absent one reports
// not found. One request is worked on at a time: push, an unused code and any
// refused operation go from idle straight to the done state, a shift passes
// through the shift state first, and a remove through the scan state, which
// walks the RAM one entry per cycle through its read port while moving later
// entries up through its write port. A new request is taken as soon as the
// previous one has been handed to the response register, even if that response
// has not yet been collected. The RAM needs no clearing after reset, as only
// entries that have been written are ever read.

module fifo_with_keyed_removal (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] handle
   input  logic [fkr_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // [1:0] func
   input  logic [fkr_pkg::FUNC_BITS-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] out_handle, [20:16] occupancy, [23:21] zero
   output logic [fkr_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   // [1:0] status
   output logic [fkr_pkg::STATUS_BITS-1:0]     rsp_tuser
);

   fkr_pkg::req_type eng_req;
   fkr_pkg::rsp_type eng_rsp;
   logic             eng_done;
   logic             out_free;

   // Output register: one finished response waits here while the engine
   // is free to take the next request.
   logic             rsp_valid_ff;
   fkr_pkg::rsp_type rsp_data_ff;

   assign eng_req.func   = req_tuser;
   assign eng_req.handle = req_tdata[fkr_pkg::HANDLE_BITS-1:0];

   // The engine only hands over a response when the register is empty or is
   // being emptied in this cycle, so no response can be overwritten.
   assign out_free = !rsp_valid_ff || rsp_tready;

   fkr_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req      (eng_req),
      .req_ready(req_tready),
      .out_free (out_free),
      .rsp_valid(eng_done),
      .rsp      (eng_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (eng_done) begin
         rsp_data_ff <= eng_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = fkr_pkg::RSP_TDATA_BITS'({rsp_data_ff.occupancy,
                                                 rsp_data_ff.out_handle});

   // A response is never handed over while the previous one is still held.
   assert property (@(posedge clock) disable iff (reset)
      eng_done |-> (!rsp_valid_ff || rsp_tready))
      else $error("response handed over while the output register is occupied");

   // A refused push always reports a full queue.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.status == fkr_pkg::STATUS_FULL)
         |-> (rsp_data_ff.occupancy == fkr_pkg::DEPTH_CNT))
      else $error("full status with occupancy below the queue depth");

   // An empty shift reports an empty queue and no handle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.status == fkr_pkg::STATUS_EMPTY)
         |-> (rsp_data_ff.occupancy == '0 && rsp_data_ff.out_handle == '0))
      else $error("empty status with entries or a handle present");

   // A request is taken only when no response is being handed over.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !eng_done)
      else $error("request accepted while a response was completing");

endmodule
